// File: hw/rtl/tbrg_pkg.sv
// Shared types, constants and register codes of the tipping bucket rain gauge.
package tbrg_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 24;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAIN_WIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TMO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACT_INT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_INT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH    = 3'd5;

  localparam logic [15:0] RST_DEBOUNCE = 16'd150;
  localparam logic [23:0] RST_RAIN_WIN = 24'd360000;
  localparam logic [23:0] RST_IDLE_TMO = 24'd1200000;
  localparam logic [23:0] RST_ACT_INT  = 24'd60000;
  localparam logic [23:0] RST_IDLE_INT = 24'd1800000;
  localparam logic [15:0] RST_DEPTH    = 16'd2794;

  localparam int unsigned TOTAL_W  = 34;
  localparam int unsigned RATE_W   = 24;
  localparam int unsigned UPTIME_W = 23;
  localparam int unsigned TIPS_W   = 24;
  localparam int unsigned PERIOD_W = 16;

  localparam int unsigned DVD_W = 48;
  localparam int unsigned CNT_W = $clog2(DVD_W);

  localparam logic [11:0] RATE_SCALE  = 12'd3600;
  localparam logic [6:0]  TOTAL_ROUND = 7'd50;
  localparam logic [6:0]  TOTAL_DIV   = 7'd100;

  // Reciprocals give exact quotients by 100 below 2**25 and by 1000 below 2**32.
  localparam logic [24:0] RECIP_100     = 25'd21474837;
  localparam int unsigned RECIP_100_SH  = 31;
  localparam logic [28:0] RECIP_1000    = 29'd274877907;
  localparam int unsigned RECIP_1000_SH = 38;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_JUDGE,
    ST_DECIDE,
    ST_MUL,
    ST_FRAC,
    ST_TOTAL,
    ST_LOAD,
    ST_DIV,
    ST_STORE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic tick;
    logic judge;
    logic snap;
    logic mul;
    logic frac;
    logic total;
    logic div_load;
    logic div_step;
    logic div_store;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic report_go;
  } dp_sts_t;

endpackage

// File: hw/rtl/tbrg_if.sv
// Stream interfaces for the tick input and the report output channels.
interface tbrg_in_if;
  logic valid;
  logic ready;
  logic tip_edge;
  logic link_ready;

  modport source (output valid, output tip_edge, output link_ready, input ready);
  modport sink (input valid, input tip_edge, input link_ready, output ready);
endinterface

interface tbrg_out_if;
  logic                           valid;
  logic                           ready;
  logic [tbrg_pkg::TOTAL_W-1:0]   total_rain_centi_mm;
  logic [tbrg_pkg::RATE_W-1:0]    rate_deci_mm_per_h;
  logic                           raining;
  logic [tbrg_pkg::UPTIME_W-1:0]  uptime_s;
  logic [tbrg_pkg::TIPS_W-1:0]    total_tips;

  modport source (output valid, output total_rain_centi_mm, output rate_deci_mm_per_h,
                  output raining, output uptime_s, output total_tips, input ready);
  modport sink (input valid, input total_rain_centi_mm, input rate_deci_mm_per_h,
                input raining, input uptime_s, input total_tips, output ready);
endinterface

// File: hw/rtl/tbrg_ctrl.sv
// Controller state machine that sequences tick handling, report arithmetic and output.
module tbrg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tbrg_pkg::dp_sts_t sts_i,
  output tbrg_pkg::dp_cmd_t cmd_o
);
  import tbrg_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.tick = 1'b1;
          state_d    = ST_JUDGE;
        end
      end
      ST_JUDGE: begin
        cmd_o.judge = 1'b1;
        state_d     = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.report_go) begin
          cmd_o.snap = 1'b1;
          state_d    = ST_MUL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FRAC;
      end
      ST_FRAC: begin
        cmd_o.frac = 1'b1;
        state_d    = ST_TOTAL;
      end
      ST_TOTAL: begin
        cmd_o.total = 1'b1;
        state_d     = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.div_store = 1'b1;
        state_d         = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/tbrg_datapath.sv
// Datapath with configuration, timers, tip counters, multipliers, divider and output register.
module tbrg_datapath #(
  parameter int unsigned TIME_WIDTH = tbrg_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tbrg_pkg::dp_cmd_t                   cmd_i,
  output tbrg_pkg::dp_sts_t                   sts_o,
  input  logic                                cfg_we_i,
  input  logic [tbrg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tbrg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                tip_edge_i,
  input  logic                                link_ready_i,
  output logic [tbrg_pkg::TOTAL_W-1:0]        total_rain_centi_mm_o,
  output logic [tbrg_pkg::RATE_W-1:0]         rate_deci_mm_per_h_o,
  output logic                                raining_o,
  output logic [tbrg_pkg::UPTIME_W-1:0]       uptime_s_o,
  output logic [tbrg_pkg::TIPS_W-1:0]         total_tips_o
);
  import tbrg_pkg::*;

  localparam int unsigned DVS_W = TIME_WIDTH + 1;
  localparam longint unsigned TIME_MAX = (64'd1 << TIME_WIDTH) - 64'd1;
  localparam logic [TIME_WIDTH-1:0] RPT_RST =
    TIME_WIDTH'((64'(RST_ACT_INT) > TIME_MAX) ? TIME_MAX : 64'(RST_ACT_INT));

  logic [15:0] debounce_q;
  logic [23:0] rain_win_q, idle_tmo_q, act_int_q, idle_int_q;
  logic [15:0] depth_q;

  logic                  tip_q, ready_q;
  logic [31:0]           uptime_q;
  logic [TIME_WIDTH-1:0] since_tip_q, since_rpt_q;
  logic [TIPS_W-1:0]     tips_q;
  logic [PERIOD_W-1:0]   period_q;

  logic [31:0]           p1_q;
  logic [43:0]           num_q;
  logic [TIME_WIDTH-1:0] elapsed_q;
  logic                  raining_snap_q;
  logic [TIPS_W-1:0]     tips_snap_q;

  logic [17:0]           tips_hi_q;
  logic [6:0]            tips_lo_q;
  logic [TOTAL_W-1:0]    hi_depth_q;
  logic [22:0]           lo_depth_q;

  logic [48:0]           tips_recip;
  logic [60:0]           uptime_recip;
  logic [24:0]           hi_times_100;
  logic [TIPS_W-1:0]     tips_lo_full;
  logic [47:0]           lo_recip;

  logic [DVD_W-1:0]      dvd_q;
  logic [DVS_W-1:0]      dvs_q, rem_q;
  logic [DVS_W:0]        rem_sh, rem_sub;
  logic                  rem_ge;

  logic [TOTAL_W-1:0]    res_total_q;
  logic [RATE_W-1:0]     res_rate_q;
  logic [UPTIME_W-1:0]   res_uptime_q;

  logic [TOTAL_W-1:0]    out_total_q;
  logic [RATE_W-1:0]     out_rate_q;
  logic                  out_raining_q;
  logic [UPTIME_W-1:0]   out_uptime_q;
  logic [TIPS_W-1:0]     out_tips_q;

  logic [23:0]           interval;
  logic                  tip_counts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= RST_DEBOUNCE;
      rain_win_q <= RST_RAIN_WIN;
      idle_tmo_q <= RST_IDLE_TMO;
      act_int_q  <= RST_ACT_INT;
      idle_int_q <= RST_IDLE_INT;
      depth_q    <= RST_DEPTH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE: debounce_q <= cfg_data_i[15:0];
        REG_RAIN_WIN: rain_win_q <= cfg_data_i;
        REG_IDLE_TMO: idle_tmo_q <= cfg_data_i;
        REG_ACT_INT:  act_int_q  <= cfg_data_i;
        REG_IDLE_INT: idle_int_q <= cfg_data_i;
        REG_DEPTH:    depth_q    <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  assign tip_counts = tip_q && (32'(since_tip_q) > 32'(debounce_q));
  assign interval   = (32'(since_tip_q) < 32'(idle_tmo_q)) ? act_int_q : idle_int_q;
  assign sts_o.report_go = ready_q && (32'(since_rpt_q) > 32'(interval));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tip_q       <= 1'b0;
      ready_q     <= 1'b0;
      uptime_q    <= '0;
      since_tip_q <= '0;
      since_rpt_q <= RPT_RST;
      tips_q      <= '0;
      period_q    <= '0;
    end else if (cmd_i.tick) begin
      tip_q       <= tip_edge_i;
      ready_q     <= link_ready_i;
      uptime_q    <= (uptime_q == '1) ? uptime_q : uptime_q + 1'b1;
      since_tip_q <= (since_tip_q == '1) ? since_tip_q : since_tip_q + 1'b1;
      since_rpt_q <= (since_rpt_q == '1) ? since_rpt_q : since_rpt_q + 1'b1;
    end else if (cmd_i.judge) begin
      if (tip_counts) begin
        tips_q      <= (tips_q == '1) ? tips_q : tips_q + 1'b1;
        period_q    <= (period_q == '1) ? period_q : period_q + 1'b1;
        since_tip_q <= '0;
      end
    end else if (cmd_i.snap) begin
      period_q    <= '0;
      since_rpt_q <= '0;
    end
  end

  // The total is split as tips = 100 * hi + lo, so only small values need a division by 100.
  assign tips_recip   = 49'(tips_q) * 49'(RECIP_100);
  assign uptime_recip = 61'(uptime_q) * 61'(RECIP_1000);
  assign hi_times_100 = 25'(tips_hi_q) * 25'(TOTAL_DIV);
  assign tips_lo_full = tips_snap_q - hi_times_100[TIPS_W-1:0];
  assign lo_recip     = 48'(lo_depth_q) * 48'(RECIP_100);

  always_ff @(posedge clk_i) begin
    if (cmd_i.snap) begin
      p1_q           <= 32'(period_q) * 32'(depth_q);
      elapsed_q      <= since_rpt_q;
      raining_snap_q <= 32'(since_tip_q) < 32'(rain_win_q);
      tips_snap_q    <= tips_q;
      tips_hi_q      <= tips_recip[RECIP_100_SH +: 18];
      res_uptime_q   <= uptime_recip[RECIP_1000_SH +: UPTIME_W];
    end
    if (cmd_i.mul) begin
      num_q      <= 44'(p1_q) * 44'(RATE_SCALE);
      tips_lo_q  <= tips_lo_full[6:0];
      hi_depth_q <= TOTAL_W'(tips_hi_q) * TOTAL_W'(depth_q);
    end
    if (cmd_i.frac) begin
      lo_depth_q <= 23'(tips_lo_q) * 23'(depth_q) + 23'(TOTAL_ROUND);
    end
    if (cmd_i.total) begin
      res_total_q <= hi_depth_q + TOTAL_W'(lo_recip[RECIP_100_SH +: 17]);
    end
  end

  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= '0;
      dvd_q <= DVD_W'({num_q, 1'b0}) + DVD_W'(elapsed_q);
      dvs_q <= {elapsed_q, 1'b0};
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], rem_ge};
    end
    if (cmd_i.div_store) begin
      res_rate_q <= (|dvd_q[DVD_W-1:RATE_W]) ? '1 : dvd_q[RATE_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_total_q   <= res_total_q;
      out_rate_q    <= res_rate_q;
      out_raining_q <= raining_snap_q;
      out_uptime_q  <= res_uptime_q;
      out_tips_q    <= tips_snap_q;
    end
  end

  assign total_rain_centi_mm_o = out_total_q;
  assign rate_deci_mm_per_h_o  = out_rate_q;
  assign raining_o             = out_raining_q;
  assign uptime_s_o            = out_uptime_q;
  assign total_tips_o          = out_tips_q;

endmodule

// File: hw/rtl/tipping_bucket_rain_gauge.sv
// Top level of the tipping bucket rain gauge counter.
//
// Each input transaction is one millisecond tick carrying a bucket tip edge and a link-ready
// flag. A tick that leads to no report passes through the judge and decide states before the
// next tick can be accepted. A tick that leads to a report passes in order through judging
// the tip and deciding, the 3600 scaling multiply and the reciprocal multiplications that
// give total rain and uptime, one 48-step restoring division of the rate by twice the
// elapsed time with its load and store, the load of the output register and the return to
// idle; the rate divider is the longest step. The report is held in an output register, so
// the next tick is accepted while a report transaction still waits; a further report waits
// until that register is free. Configuration writes take effect at once and are meant for
// times when the block is idle.
module tipping_bucket_rain_gauge #(
  parameter int unsigned TIME_WIDTH = tbrg_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tbrg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tbrg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tbrg_in_if.sink                         in_if,
  tbrg_out_if.source                      out_if
);
  import tbrg_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tbrg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tbrg_datapath #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .tip_edge_i            (in_if.tip_edge),
    .link_ready_i          (in_if.link_ready),
    .total_rain_centi_mm_o (out_if.total_rain_centi_mm),
    .rate_deci_mm_per_h_o  (out_if.rate_deci_mm_per_h),
    .raining_o             (out_if.raining),
    .uptime_s_o            (out_if.uptime_s),
    .total_tips_o          (out_if.total_tips)
  );

endmodule
